// ----- design/srpg_pkg.sv -----
// Shared types, codes and sizes of the stepper ramp profile generator.
// Used by srpg_cfg, the core and the testbench; depends on nothing else.
package srpg_pkg;

    // Depth of the acceleration and deceleration period tables.
    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    // Ramp position must be able to hold TABLE_DEPTH itself.
    localparam int RAMP_W      = $clog2(TABLE_DEPTH + 1);

    localparam int PERIOD_W    = 32;
    localparam int STEPS_W     = 16;
    localparam int INDEX_W     = 6;
    localparam int MSTEP_W     = 21;
    localparam int SHIFT_W     = 3;
    localparam int LEN_W       = 7;
    localparam int MAX_SHIFT   = 5;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 64;

    localparam logic [STEPS_W-1:0] FULL_STEP_MASK = 16'hffff;

    typedef enum logic [2:0] {
        MODE_LOAD_ACCEL = 3'd0,
        MODE_LOAD_DECEL = 3'd1,
        MODE_START      = 3'd2,
        MODE_TICK       = 3'd3,
        MODE_STOP       = 3'd4,
        MODE_LOCK       = 3'd5,
        MODE_UNLOCK     = 3'd6,
        MODE_UNUSED     = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        PH_INIT   = 3'd0,
        PH_HOLD   = 3'd1,
        PH_ACCEL  = 3'd2,
        PH_CONST  = 3'd3,
        PH_DECEL  = 3'd4,
        PH_PARKED = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEPPING_LOG2 = 3'd0,
        CFG_ACCEL_LENGTH  = 3'd1,
        CFG_DECEL_LENGTH  = 3'd2,
        CFG_DIRECTION     = 3'd3,
        CFG_HOLD_PRESENT  = 3'd4
    } cfg_index_t;

    // Configuration as seen by the datapath, lengths and shift already clamped.
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [RAMP_W-1:0]  accel_len;
        logic [RAMP_W-1:0]  decel_len;
        logic               direction;
        logic               hold_present;
    } cfg_t;

endpackage

// ----- design/srpg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the period tables; no dependencies.
module srpg_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/srpg_cfg.sv -----
// Configuration register file of the ramp generator; clamps the stepping shift
// and the table lengths. Depends on srpg_pkg.
module srpg_cfg
    import srpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [SHIFT_W-1:0] stepping_reg;
    logic [LEN_W-1:0]   accel_len_reg;
    logic [LEN_W-1:0]   decel_len_reg;
    logic               direction_reg;
    logic               hold_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stepping_reg     <= '0;
            accel_len_reg    <= '0;
            decel_len_reg    <= '0;
            direction_reg    <= 1'b0;
            hold_present_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_STEPPING_LOG2: stepping_reg     <= wr_data[SHIFT_W-1:0];
                CFG_ACCEL_LENGTH:  accel_len_reg    <= wr_data[LEN_W-1:0];
                CFG_DECEL_LENGTH:  decel_len_reg    <= wr_data[LEN_W-1:0];
                CFG_DIRECTION:     direction_reg    <= wr_data[0];
                CFG_HOLD_PRESENT:  hold_present_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    // A length beyond the table is taken as the full table.
    function automatic logic [RAMP_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        if (32'(len) > TABLE_DEPTH)
        begin
            return RAMP_W'(TABLE_DEPTH);
        end
        return RAMP_W'(len);
    endfunction

    always_comb
    begin
        cfg.shift        = (32'(stepping_reg) > MAX_SHIFT) ? SHIFT_W'(MAX_SHIFT)
                                                            : stepping_reg;
        cfg.accel_len    = clamp_len(accel_len_reg);
        cfg.decel_len    = clamp_len(decel_len_reg);
        cfg.direction    = direction_reg;
        cfg.hold_present = hold_present_reg;
    end

endmodule

// ----- design/stepper_ramp_profile_generator_core.sv -----
// Stepper ramp profile generator: an accepted input request waits in ST_EXEC for
// the registered read of the period table RAMs and for a free output register,
// then is resolved into it; no new request is accepted before that.
// Reset (rst_n, asynchronous, active low) parks the run with the pulse, driver
// and hold pins low and clears counters and configuration; the period tables are
// not cleared. Depends on srpg_pkg, srpg_cfg and srpg_ram.
module stepper_ramp_profile_generator_core
    import srpg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input requests.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: table_index[5:0], period_value[37:6], run_steps[53:38], zero pad.
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: mode[2:0].
    input  logic [2:0]             s_axis_tuser,
    // Result requests.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: period_out[31:0], period_update[32], pulse_enable[33],
    // driver_enable[34], hold_pin[35], direction_pin[36], run_state[39:37],
    // full_steps_done[55:40], stopped_flag[56], done_event[57], zero pad.
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // The block takes one request, reads both period tables at the address
    // that the current ramp state points to, and once the output register is
    // free or being drained resolves the request with the read data and loads
    // the output register. Because only one request is in flight, a table load
    // and a later read of the same entry never overlap and need no forwarding.

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    cfg_t cfg;

    // Input request fields.
    logic [INDEX_W-1:0]  in_index;
    logic [PERIOD_W-1:0] in_period;
    logic [STEPS_W-1:0]  in_steps;
    mode_t               in_mode;

    logic in_accept;

    // Latched request.
    mode_t              mode_reg;
    logic [STEPS_W-1:0] steps_reg;

    // Run state.
    phase_t              phase_reg, phase_next;
    logic [RAMP_W-1:0]   ramp_reg, ramp_next;
    logic [MSTEP_W-1:0]  left_reg, left_next;
    logic [MSTEP_W-1:0]  taken_reg, taken_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                pulse_reg, pulse_next;
    logic                driver_reg, driver_next;
    logic                hold_reg, hold_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // Table RAM ports.
    logic                accel_wr_en;
    logic                decel_wr_en;
    logic [TBL_AW-1:0]   wr_addr;
    logic [TBL_AW-1:0]   rd_addr;
    logic [PERIOD_W-1:0] accel_rd_data;
    logic [PERIOD_W-1:0] decel_rd_data;

    logic                exec_fire;
    logic                upd;
    logic                done;
    logic [STEPS_W-1:0]  full_steps;
    logic                stopped;

    assign in_index  = s_axis_tdata[INDEX_W-1:0];
    assign in_period = s_axis_tdata[INDEX_W +: PERIOD_W];
    assign in_steps  = s_axis_tdata[INDEX_W + PERIOD_W +: STEPS_W];
    assign in_mode   = mode_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    srpg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Loads write the table straight at acceptance. Indexes beyond the table
    // are dropped.
    always_comb
    begin
        wr_addr     = TBL_AW'(in_index);
        accel_wr_en = in_accept && (in_mode == MODE_LOAD_ACCEL)
                      && (32'(in_index) < TABLE_DEPTH);
        decel_wr_en = in_accept && (in_mode == MODE_LOAD_DECEL)
                      && (32'(in_index) < TABLE_DEPTH);
        // A start, or the first tick after it, reads entry zero; otherwise the
        // current ramp position is read. Reads only matter while it is in range.
        if ((in_mode == MODE_START) || (phase_reg == PH_INIT))
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = TBL_AW'(ramp_reg);
        end
    end

    srpg_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_accel_ram (
        .clk     (clk),
        .wr_en   (accel_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_period),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (accel_rd_data)
    );

    srpg_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_decel_ram (
        .clk     (clk),
        .wr_en   (decel_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_period),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (decel_rd_data)
    );

    // The request resolves once the output register is free or being drained.
    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Resolve the latched request against the run state and the table data.
    always_comb
    begin
        phase_next  = phase_reg;
        ramp_next   = ramp_reg;
        left_next   = left_reg;
        taken_next  = taken_reg;
        period_next = period_reg;
        pulse_next  = pulse_reg;
        driver_next = driver_reg;
        hold_next   = hold_reg;
        upd         = 1'b0;
        done        = 1'b0;

        unique case (mode_reg)
            MODE_START:
            begin
                period_next = accel_rd_data;
                upd         = 1'b1;
                left_next   = MSTEP_W'(steps_reg) << cfg.shift;
                taken_next  = '0;
                ramp_next   = '0;
                phase_next  = PH_INIT;
                if (cfg.hold_present)
                begin
                    hold_next = 1'b0;
                end
                driver_next = 1'b1;
                pulse_next  = 1'b1;
            end
            MODE_TICK:
            begin
                if (pulse_reg)
                begin
                    if (phase_next == PH_INIT)
                    begin
                        phase_next = PH_ACCEL;
                        ramp_next  = '0;
                    end
                    if (phase_next == PH_ACCEL)
                    begin
                        if (ramp_next < cfg.accel_len)
                        begin
                            period_next = accel_rd_data;
                            upd         = 1'b1;
                            ramp_next   = ramp_next + 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CONST;
                        end
                    end
                    else if (phase_next == PH_CONST)
                    begin
                        // Enter the deceleration ramp once fewer microsteps are
                        // left than twice its length.
                        if (left_reg < MSTEP_W'({cfg.decel_len, 1'b0}))
                        begin
                            phase_next = PH_DECEL;
                            ramp_next  = RAMP_W'(1);
                        end
                    end
                    else if (phase_next == PH_DECEL)
                    begin
                        if (ramp_next < cfg.decel_len)
                        begin
                            period_next = decel_rd_data;
                            upd         = 1'b1;
                            ramp_next   = ramp_next + 1'b1;
                        end
                    end

                    if (left_reg != '0)
                    begin
                        left_next  = left_reg - 1'b1;
                        taken_next = taken_reg + 1'b1;
                    end
                    if (left_next == '0)
                    begin
                        driver_next = 1'b0;
                        pulse_next  = 1'b0;
                        phase_next  = PH_PARKED;
                        done        = 1'b1;
                    end
                end
            end
            MODE_STOP:
            begin
                driver_next = 1'b0;
                pulse_next  = 1'b0;
                phase_next  = PH_PARKED;
                done        = 1'b1;
            end
            MODE_LOCK:
            begin
                if (cfg.hold_present)
                begin
                    pulse_next  = 1'b0;
                    hold_next   = 1'b1;
                    driver_next = 1'b1;
                    phase_next  = PH_HOLD;
                end
            end
            MODE_UNLOCK:
            begin
                if (cfg.hold_present)
                begin
                    pulse_next  = 1'b0;
                    driver_next = 1'b0;
                    hold_next   = 1'b0;
                    phase_next  = PH_PARKED;
                end
            end
            default: ;
        endcase

        full_steps = STEPS_W'(taken_next >> cfg.shift) & FULL_STEP_MASK;
        stopped    = (phase_next == PH_INIT) || (phase_next == PH_HOLD)
                     || (phase_next == PH_PARKED);

        out_data_next = {6'b0, done, stopped, full_steps, phase_next, !cfg.direction,
                         hold_next, driver_next, pulse_next, upd, period_next};

        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PARKED;
            ramp_reg      <= '0;
            left_reg      <= '0;
            taken_reg     <= '0;
            period_reg    <= '0;
            pulse_reg     <= 1'b0;
            driver_reg    <= 1'b0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                phase_reg  <= phase_next;
                ramp_reg   <= ramp_next;
                left_reg   <= left_next;
                taken_reg  <= taken_next;
                period_reg <= period_next;
                pulse_reg  <= pulse_next;
                driver_reg <= driver_next;
                hold_reg   <= hold_next;
            end
        end
    end

    // Request and result payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg  <= in_mode;
            steps_reg <= in_steps;
        end
        if (exec_fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Only one request is in flight: an accepted request closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // Pulses never run without the driver enabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> driver_reg)
        else $error("pulses running with the driver disabled");

    // Pulses never run while the run is held or parked.
    assert property (@(posedge clk) disable iff (!rst_n)
        pulse_reg |-> (phase_reg != PH_HOLD) && (phase_reg != PH_PARKED))
        else $error("pulses running while held or parked");

    // A resolved request always leaves a result waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> m_axis_tvalid)
        else $error("resolved request produced no result");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the stepper ramp profile generator core.
// It needs srpg_pkg and the design sources. Its own scoreboard predicts every result.
module testbench;
    import srpg_pkg::*;

    localparam int RESET_CYCLES  = 12;
    // Result requests trail input requests, and the settling after a drain leaves
    // plenty of margin before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;
    // Cycles with no request accepted on any channel before the run is called hung.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 150;

    // One input request as the generator sees it.
    typedef struct {
        mode_t               mode;
        logic [INDEX_W-1:0]  index;
        logic [PERIOD_W-1:0] period;
        logic [STEPS_W-1:0]  steps;
    } ramp_request_t;

    // Result tdata layout. The first member is the most significant.
    typedef struct packed {
        logic [5:0]          pad;
        logic                done;
        logic                stopped;
        logic [STEPS_W-1:0]  full_steps;
        phase_t              state;
        logic                dir_pin;
        logic                hold;
        logic                driver;
        logic                pulse;
        logic                update;
        logic [PERIOD_W-1:0] period;
    } ramp_result_t;

    // The scoreboard keeps its own copy of the period tables, the configuration and
    // the run state. It works out the result of each accepted input request and
    // queues it. Results from the block are then checked against that queue in order.
    class ramp_scoreboard;
        logic [PERIOD_W-1:0] accel_periods [TABLE_DEPTH];
        logic [PERIOD_W-1:0] decel_periods [TABLE_DEPTH];
        logic [SHIFT_W-1:0]  stepping_reg;
        logic [LEN_W-1:0]    accel_len_reg;
        logic [LEN_W-1:0]    decel_len_reg;
        logic                dir_reg;
        logic                hold_reg;
        logic [RAMP_W-1:0]   ramp_pos;
        phase_t              run_phase;
        logic [MSTEP_W-1:0]  steps_left;
        logic [MSTEP_W-1:0]  steps_taken;
        logic [PERIOD_W-1:0] period;
        logic                pulse_on;
        logic                driver_on;
        logic                hold_on;
        ramp_result_t        expected_q [$];
        int                  errors;

        function new();
            stepping_reg  = '0;
            accel_len_reg = '0;
            decel_len_reg = '0;
            dir_reg       = 1'b0;
            hold_reg      = 1'b0;
            ramp_pos      = '0;
            run_phase     = PH_PARKED;
            steps_left    = '0;
            steps_taken   = '0;
            period        = '0;
            pulse_on      = 1'b0;
            driver_on     = 1'b0;
            hold_on       = 1'b0;
            errors        = 0;
        endfunction

        function int shift_now();
            return (stepping_reg > MAX_SHIFT) ? MAX_SHIFT : int'(stepping_reg);
        endfunction

        function int clamp_len(logic [LEN_W-1:0] len);
            return (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_cfg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STEPPING_LOG2: stepping_reg  = data[SHIFT_W-1:0];
                CFG_ACCEL_LENGTH:  accel_len_reg = data[LEN_W-1:0];
                CFG_DECEL_LENGTH:  decel_len_reg = data[LEN_W-1:0];
                CFG_DIRECTION:     dir_reg       = data[0];
                CFG_HOLD_PRESENT:  hold_reg      = data[0];
                default: ;
            endcase
        endfunction

        // Parking turns the driver and the pulses off. The hold pin stays as it is.
        function void park();
            driver_on = 1'b0;
            pulse_on  = 1'b0;
            run_phase = PH_PARKED;
        endfunction

        function void note_request(ramp_request_t r);
            ramp_result_t res;
            int           alen;
            int           dlen;
            res  = '0;
            alen = clamp_len(accel_len_reg);
            dlen = clamp_len(decel_len_reg);
            case (r.mode)
                MODE_LOAD_ACCEL:
                    if (r.index < TABLE_DEPTH) accel_periods[r.index] = r.period;
                MODE_LOAD_DECEL:
                    if (r.index < TABLE_DEPTH) decel_periods[r.index] = r.period;
                MODE_START: begin
                    period      = accel_periods[0];
                    res.update  = 1'b1;
                    steps_left  = MSTEP_W'(r.steps) << shift_now();
                    steps_taken = '0;
                    ramp_pos    = '0;
                    run_phase   = PH_INIT;
                    if (hold_reg) hold_on = 1'b0;
                    driver_on   = 1'b1;
                    pulse_on    = 1'b1;
                end
                MODE_TICK:
                    if (pulse_on) begin
                        if (run_phase == PH_INIT) begin
                            run_phase = PH_ACCEL;
                            ramp_pos  = '0;
                        end
                        if (run_phase == PH_ACCEL) begin
                            // Spend the acceleration table, then hold the period.
                            if (ramp_pos < alen) begin
                                period     = accel_periods[ramp_pos];
                                res.update = 1'b1;
                                ramp_pos++;
                            end else begin
                                run_phase = PH_CONST;
                            end
                        end else if (run_phase == PH_CONST) begin
                            if (steps_left < 2 * dlen) begin
                                run_phase = PH_DECEL;
                                ramp_pos  = 1;
                            end
                        end else if (run_phase == PH_DECEL) begin
                            if (ramp_pos < dlen) begin
                                period     = decel_periods[ramp_pos];
                                res.update = 1'b1;
                                ramp_pos++;
                            end
                        end
                        if (steps_left != 0) begin
                            steps_left--;
                            steps_taken++;
                        end
                        if (steps_left == 0) begin
                            park();
                            res.done = 1'b1;
                        end
                    end
                MODE_STOP: begin
                    park();
                    res.done = 1'b1;
                end
                MODE_LOCK:
                    if (hold_reg) begin
                        pulse_on  = 1'b0;
                        hold_on   = 1'b1;
                        driver_on = 1'b1;
                        run_phase = PH_HOLD;
                    end
                MODE_UNLOCK:
                    if (hold_reg) begin
                        pulse_on  = 1'b0;
                        driver_on = 1'b0;
                        hold_on   = 1'b0;
                        run_phase = PH_PARKED;
                    end
                default: ;
            endcase
            res.period     = period;
            res.pulse      = pulse_on;
            res.driver     = driver_on;
            res.hold       = hold_on;
            res.dir_pin    = ~dir_reg;
            res.state      = run_phase;
            res.full_steps = STEPS_W'(steps_taken >> shift_now()) & FULL_STEP_MASK;
            res.stopped    = run_phase inside {PH_INIT, PH_HOLD, PH_PARKED};
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] raw);
            ramp_result_t got;
            ramp_result_t want;
            got = ramp_result_t'(raw);
            if (expected_q.size() == 0) begin
                $error("result request 0x%h arrived with nothing expected", raw);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("period_out", want.period, got.period);
            compare_field("period_update", want.update, got.update);
            compare_field("pulse_enable", want.pulse, got.pulse);
            compare_field("driver_enable", want.driver, got.driver);
            compare_field("hold_pin", want.hold, got.hold);
            compare_field("direction_pin", want.dir_pin, got.dir_pin);
            compare_field("run_state", want.state, got.state);
            compare_field("full_steps_done", want.full_steps, got.full_steps);
            compare_field("stopped_flag", want.stopped, got.stopped);
            compare_field("done_event", want.done, got.done);
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [2:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    ramp_scoreboard sb = new();

    // Pacing of the two sides, in percent of cycles. Each phase of the run changes these.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int requests_sent  = 0;
    int idle_cycles    = 0;

    always #6 clk = ~clk;

    stepper_ramp_profile_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The receiver stalls at random, cycle by cycle, at the rate of the current phase.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result requests are sampled at the edge where they are accepted.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // The watchdog fails the run after a long stretch in which no channel moves.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic ramp_request_t make_req(mode_t m, logic [INDEX_W-1:0] idx,
                                               logic [PERIOD_W-1:0] val,
                                               logic [STEPS_W-1:0] steps);
        ramp_request_t r;
        r.mode   = m;
        r.index  = idx;
        r.period = val;
        r.steps  = steps;
        return r;
    endfunction

    // A request with every field random, unused mode included.
    function automatic ramp_request_t random_req();
        return make_req(mode_t'($urandom_range(7)), INDEX_W'($urandom_range(63)), $urandom(),
                        STEPS_W'($urandom_range(65535)));
    endfunction

    // Sends one input request and notes it at the edge where it is accepted.
    // tvalid stays high after acceptance, so back-to-back requests need no extra step.
    // A gap lowers it, and so does the drain.
    task automatic send_req(ramp_request_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, r.steps, r.period, r.index};
        s_axis_tuser  <= r.mode;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Holds the sender off until every expected result has come back, then settles.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.apply_cfg(idx, data);
    endtask

    // Writes all five registers. Call this only while the block is idle.
    task automatic configure(logic [SHIFT_W-1:0] stepping, logic [LEN_W-1:0] alen,
                             logic [LEN_W-1:0] dlen, logic dir, logic hold);
        write_cfg(CFG_STEPPING_LOG2, CFG_DATA_W'(stepping));
        write_cfg(CFG_ACCEL_LENGTH, alen);
        write_cfg(CFG_DECEL_LENGTH, dlen);
        write_cfg(CFG_DIRECTION, CFG_DATA_W'(dir));
        write_cfg(CFG_HOLD_PRESENT, CFG_DATA_W'(hold));
        cfg_valid <= 1'b0;
    endtask

    // Pacing modes: none, sender idle, receiver stalling, then both sides at once.
    task automatic set_pace(int sel);
        case (sel)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    // A well-formed run: a start, then ticks until the run parks. The step count is
    // mostly sized to pass through acceleration, constant speed and deceleration (else
    // up to 3 steps). Random requests mixed in may restart, stop or lock the motor.
    task automatic ramp_run();
        int                 total;
        int                 guard;
        logic [STEPS_W-1:0] steps;
        total = sb.clamp_len(sb.accel_len_reg) + 2 * sb.clamp_len(sb.decel_len_reg)
                + $urandom_range(12);
        if ($urandom_range(7) == 0)
            steps = STEPS_W'($urandom_range(3));
        else
            steps = STEPS_W'((total >> sb.shift_now()) + $urandom_range(1));
        send_req(make_req(MODE_START, INDEX_W'($urandom_range(63)), $urandom(), steps));
        guard = 0;
        while (sb.pulse_on && guard < 600) begin
            if ($urandom_range(19) == 0)
                send_req(random_req());
            else
                send_req(make_req(MODE_TICK, INDEX_W'($urandom_range(63)), $urandom(),
                                  STEPS_W'($urandom_range(65535))));
            guard++;
        end
    endtask

    // Broken sequences: a start with a random step count that is cut short, or a burst
    // of random requests.
    task automatic broken_sequence();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(1) == 1) begin
            send_req(make_req(MODE_START, '0, $urandom(), STEPS_W'($urandom_range(65535))));
            repeat (n) send_req(make_req(MODE_TICK, '0, '0, '0));
            send_req(random_req());
        end else begin
            repeat (n) send_req(random_req());
        end
    endtask

    // One random phase. Halfway through, the sender pauses until every expected
    // result has come back.
    task automatic random_phase(int budget);
        int  first;
        bit  paused;
        first  = requests_sent;
        paused = 1'b0;
        while (requests_sent - first < budget) begin
            if (!paused && requests_sent - first >= budget / 2) begin
                paused = 1'b1;
                drain_results();
            end
            if ($urandom_range(3) != 0)
                ramp_run();
            else
                broken_sequence();
        end
    endtask

    initial begin
        int p;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pace(0);
        configure(3'd0, 7'd4, 7'd3, 1'b0, 1'b1);

        // Both tables are filled first. An entry that was never written is then never
        // read, whatever the lengths are later set to.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_req(make_req(MODE_LOAD_ACCEL, INDEX_W'(i), $urandom(), '0));
            send_req(make_req(MODE_LOAD_DECEL, INDEX_W'(i), $urandom(), '0));
        end

        // Directed cases. Accel length is 4, decel length is 3, one microstep per step,
        // and the hold pin is present.
        send_req(make_req(MODE_LOAD_ACCEL, 6'd63, 32'hffff_ffff, 16'hffff));
        send_req(make_req(MODE_LOAD_DECEL, 6'd0, 32'h0, 16'h0));
        send_req(make_req(MODE_START, '0, '0, 16'd0));       // zero steps
        send_req(make_req(MODE_TICK, '0, '0, '0));           // first tick parks at once
        send_req(make_req(MODE_TICK, '0, '0, '0));           // pulses off: ignored
        send_req(make_req(MODE_STOP, '0, '0, '0));           // stop while already parked
        send_req(make_req(MODE_LOCK, '0, '0, '0));
        send_req(make_req(MODE_UNLOCK, '0, '0, '0));
        send_req(make_req(MODE_UNUSED, 6'd63, 32'hffff_ffff, 16'hffff));
        send_req(make_req(MODE_START, '0, '0, 16'd3));
        repeat (3) send_req(make_req(MODE_TICK, '0, '0, '0));
        send_req(make_req(MODE_START, '0, '0, 16'd10));
        repeat (2) send_req(make_req(MODE_TICK, '0, '0, '0));
        send_req(make_req(MODE_START, '0, '0, 16'd2));       // restart while running
        send_req(make_req(MODE_TICK, '0, '0, '0));
        send_req(make_req(MODE_LOCK, '0, '0, '0));           // lock while running
        send_req(make_req(MODE_TICK, '0, '0, '0));
        send_req(make_req(MODE_START, '0, '0, 16'hffff));    // start from hold, full count
        send_req(make_req(MODE_TICK, '0, '0, '0));
        send_req(make_req(MODE_STOP, '0, '0, '0));

        // The random phases walk through settings that include the extremes: top
        // stepping and out-of-range values, zero and out-of-range lengths, and both
        // directions with and without the hold pin. Later phases draw their settings
        // at random.
        for (p = 0; p < 8; p++) begin
            drain_results();
            case (p)
                0: configure(3'd5, 7'd64, 7'd64, 1'b1, 1'b0);
                1: configure(3'd7, 7'd127, 7'd100, 1'b0, 1'b1);
                2: configure(3'd0, 7'd0, 7'd0, 1'b1, 1'b1);
                3: configure(3'd6, 7'd1, 7'd65, 1'b0, 1'b0);
                default:
                    configure(SHIFT_W'($urandom_range(7)),
                              LEN_W'($urandom_range(1) ? $urandom_range(16) : $urandom_range(127)),
                              LEN_W'($urandom_range(1) ? $urandom_range(16) : $urandom_range(127)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            set_pace(p % 4);
            random_phase(PHASE_ITEMS);
        end

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
